// ===== hdl/wsfe_pkg.sv =====
// ----------------------------------------------------------------------------
// wsfe_pkg: shared types and constants for the masked frame encoder
// Entry format between front and back, header constants, back state codes.
// ----------------------------------------------------------------------------
package wsfe_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int LEN_W       = 63;
	localparam int KEY_W       = 32;
	localparam int BYTE_W      = 8;
	localparam int EXT_W       = 64;
	localparam int EXT_CNT_W   = 4;

	localparam logic [BYTE_W-1:0] HDR_FIN_TEXT = 8'h81;
	localparam logic [BYTE_W-1:0] LEN_MASK_BIT = 8'h80;
	localparam logic [6:0]        LEN_CODE_16  = 7'd126;
	localparam logic [6:0]        LEN_CODE_64  = 7'd127;
	localparam logic [LEN_W-1:0]  LEN_SHORT_LIM = 63'd126;
	localparam logic [LEN_W-1:0]  LEN_MAX_16   = 63'hFFFF;
	localparam logic [EXT_CNT_W-1:0] EXT_BYTES_16 = 4'd2;
	localparam logic [EXT_CNT_W-1:0] EXT_BYTES_64 = 4'd8;

	typedef enum logic [1:0] {
		LEN_SHORT,
		LEN_EXT16,
		LEN_EXT64
	} len_class_t;

	typedef enum logic {
		ENT_PAYLOAD,
		ENT_START
	} ent_kind_t;

	typedef struct packed {
		ent_kind_t           kind;
		len_class_t          lclass;
		logic                len_zero;
		logic [LEN_W-1:0]    len;
		logic [KEY_W-1:0]    key;
		logic                pay_valid;
		logic [BYTE_W-1:0]   pay_byte;
		logic                pay_end;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic idle;
	} bk_stat_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_LEN,
		BK_EXT,
		BK_MASK,
		BK_PAY
	} back_state_t;

	// mask byte for a phase, byte 0 in the top bits
	function automatic logic [BYTE_W-1:0] mask_sel(input logic [KEY_W-1:0] key,
			input logic [1:0] phase);
		logic [BYTE_W-1:0] b;
		case (phase)
			2'd0:    b = key[31:24];
			2'd1:    b = key[23:16];
			2'd2:    b = key[15:8];
			default: b = key[7:0];
		endcase
		return b;
	endfunction

endpackage

// ===== hdl/wsfe_front.sv =====
// ----------------------------------------------------------------------------
// wsfe_front: item intake and classification
// Tracks frame length and mask phase, masks payload bytes, queues entries.
// ----------------------------------------------------------------------------
module wsfe_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [wsfe_pkg::BYTE_W-1:0]         payload_byte,
	input  logic                                has_byte,
	input  logic                                frame_start,
	input  logic [wsfe_pkg::LEN_W-1:0]          frame_length,
	input  logic [wsfe_pkg::KEY_W-1:0]          mask_key,
	input  wsfe_pkg::q_stat_t                   q_stat,
	output logic                                push,
	output wsfe_pkg::entry_t                    push_entry
);

	logic [wsfe_pkg::LEN_W-1:0] bytes_left_q, bytes_left_d;
	logic [1:0]                 phase_q, phase_d;
	logic [wsfe_pkg::KEY_W-1:0] mask_q, mask_d;
	logic                       accept;
	logic                       len_zero;
	logic                       pay_ok;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;
	assign len_zero = (frame_length == '0);
	assign pay_ok   = has_byte && (bytes_left_q != '0);

	always_comb begin
		bytes_left_d = bytes_left_q;
		phase_d      = phase_q;
		mask_d       = mask_q;
		push         = 1'b0;

		push_entry.kind      = wsfe_pkg::ENT_PAYLOAD;
		push_entry.lclass    = wsfe_pkg::LEN_SHORT;
		push_entry.len_zero  = len_zero;
		push_entry.len       = frame_length;
		push_entry.key       = mask_key;
		push_entry.pay_valid = 1'b0;
		push_entry.pay_byte  = payload_byte ^ wsfe_pkg::mask_sel(mask_q, phase_q);
		push_entry.pay_end   = (bytes_left_q == wsfe_pkg::LEN_W'(1));

		if (frame_length < wsfe_pkg::LEN_SHORT_LIM) begin
			push_entry.lclass = wsfe_pkg::LEN_SHORT;
		end else if (frame_length <= wsfe_pkg::LEN_MAX_16) begin
			push_entry.lclass = wsfe_pkg::LEN_EXT16;
		end else begin
			push_entry.lclass = wsfe_pkg::LEN_EXT64;
		end

		if (frame_start) begin
			push_entry.kind      = wsfe_pkg::ENT_START;
			push_entry.pay_valid = has_byte && !len_zero;
			push_entry.pay_byte  = payload_byte ^ mask_key[31:24];
			push_entry.pay_end   = (frame_length == wsfe_pkg::LEN_W'(1));
			push = accept;
			if (accept) begin
				mask_d = mask_key;
				if (has_byte && !len_zero) begin
					bytes_left_d = frame_length - wsfe_pkg::LEN_W'(1);
					phase_d      = 2'd1;
				end else begin
					bytes_left_d = frame_length;
					phase_d      = 2'd0;
				end
			end
		end else if (pay_ok) begin
			push = accept;
			if (accept) begin
				bytes_left_d = bytes_left_q - wsfe_pkg::LEN_W'(1);
				phase_d      = phase_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			phase_q      <= '0;
			mask_q       <= '0;
		end else begin
			bytes_left_q <= bytes_left_d;
			phase_q      <= phase_d;
			mask_q       <= mask_d;
		end
	end

endmodule

// ===== hdl/wsfe_queue.sv =====
// ----------------------------------------------------------------------------
// wsfe_queue: short entry queue between front and back
// Register-based FIFO, one push (while not full) and one pop (while not empty) per cycle.
// ----------------------------------------------------------------------------
module wsfe_queue #(
	parameter int DEPTH = wsfe_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  wsfe_pkg::entry_t  push_entry,
	input  logic              pop,
	output wsfe_pkg::entry_t  head,
	output wsfe_pkg::q_stat_t q_stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	wsfe_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign q_stat.full  = (count_q == CW'(DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== hdl/wsfe_back.sv =====
// ----------------------------------------------------------------------------
// wsfe_back: frame byte sequencer
// Expands queued entries into header, mask and payload bytes on the stream.
// ----------------------------------------------------------------------------
module wsfe_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  wsfe_pkg::entry_t            head,
	input  wsfe_pkg::q_stat_t           q_stat,
	output logic                        pop,
	output wsfe_pkg::bk_stat_t          bk_stat,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [wsfe_pkg::BYTE_W-1:0] m_tdata,
	output logic                        m_tlast
);

	wsfe_pkg::back_state_t state_q, state_d;
	wsfe_pkg::entry_t      ent_q, ent_d;
	logic [wsfe_pkg::EXT_W-1:0]     ext_q, ext_d;
	logic [wsfe_pkg::EXT_CNT_W-1:0] ext_cnt_q, ext_cnt_d;
	logic [wsfe_pkg::KEY_W-1:0]     mask_q, mask_d;
	logic [1:0]                     mcnt_q, mcnt_d;
	logic                           out_valid_q, out_valid_d;
	logic [wsfe_pkg::BYTE_W-1:0]    out_byte_q, out_byte_d;
	logic                           out_last_q, out_last_d;
	logic                           adv, load;

	assign adv          = !out_valid_q || m_tready;
	assign m_tvalid     = out_valid_q;
	assign m_tdata      = out_byte_q;
	assign m_tlast      = out_last_q;
	assign bk_stat.idle = (state_q == wsfe_pkg::BK_IDLE);

	always_comb begin
		state_d    = state_q;
		ent_d      = ent_q;
		ext_d      = ext_q;
		ext_cnt_d  = ext_cnt_q;
		mask_d     = mask_q;
		mcnt_d     = mcnt_q;
		out_byte_d = out_byte_q;
		out_last_d = out_last_q;
		load       = 1'b0;
		pop        = 1'b0;

		if (adv) begin
			unique case (state_q)
				wsfe_pkg::BK_IDLE: begin
					if (!q_stat.empty) begin
						pop  = 1'b1;
						load = 1'b1;
						if (head.kind == wsfe_pkg::ENT_PAYLOAD) begin
							out_byte_d = head.pay_byte;
							out_last_d = head.pay_end;
						end else begin
							out_byte_d = wsfe_pkg::HDR_FIN_TEXT;
							out_last_d = 1'b0;
							ent_d      = head;
							mask_d     = head.key;
							mcnt_d     = 2'd0;
							state_d    = wsfe_pkg::BK_LEN;
						end
					end
				end
				wsfe_pkg::BK_LEN: begin
					load       = 1'b1;
					out_last_d = 1'b0;
					unique case (ent_q.lclass)
						wsfe_pkg::LEN_EXT16: begin
							out_byte_d = wsfe_pkg::LEN_MASK_BIT | {1'b0, wsfe_pkg::LEN_CODE_16};
							ext_d      = {ent_q.len[15:0], 48'd0};
							ext_cnt_d  = wsfe_pkg::EXT_BYTES_16;
							state_d    = wsfe_pkg::BK_EXT;
						end
						wsfe_pkg::LEN_EXT64: begin
							out_byte_d = wsfe_pkg::LEN_MASK_BIT | {1'b0, wsfe_pkg::LEN_CODE_64};
							ext_d      = {1'b0, ent_q.len};
							ext_cnt_d  = wsfe_pkg::EXT_BYTES_64;
							state_d    = wsfe_pkg::BK_EXT;
						end
						default: begin
							out_byte_d = wsfe_pkg::LEN_MASK_BIT | {1'b0, ent_q.len[6:0]};
							state_d    = wsfe_pkg::BK_MASK;
						end
					endcase
				end
				wsfe_pkg::BK_EXT: begin
					load       = 1'b1;
					out_byte_d = ext_q[wsfe_pkg::EXT_W-1 -: wsfe_pkg::BYTE_W];
					out_last_d = 1'b0;
					ext_d      = ext_q << wsfe_pkg::BYTE_W;
					ext_cnt_d  = ext_cnt_q - wsfe_pkg::EXT_CNT_W'(1);
					if (ext_cnt_q == wsfe_pkg::EXT_CNT_W'(1)) begin
						state_d = wsfe_pkg::BK_MASK;
					end
				end
				wsfe_pkg::BK_MASK: begin
					load       = 1'b1;
					out_byte_d = mask_q[wsfe_pkg::KEY_W-1 -: wsfe_pkg::BYTE_W];
					out_last_d = (mcnt_q == 2'd3) && ent_q.len_zero;
					mask_d     = mask_q << wsfe_pkg::BYTE_W;
					mcnt_d     = mcnt_q + 2'd1;
					if (mcnt_q == 2'd3) begin
						state_d = ent_q.pay_valid ? wsfe_pkg::BK_PAY : wsfe_pkg::BK_IDLE;
					end
				end
				wsfe_pkg::BK_PAY: begin
					load       = 1'b1;
					out_byte_d = ent_q.pay_byte;
					out_last_d = ent_q.pay_end;
					state_d    = wsfe_pkg::BK_IDLE;
				end
				default: begin
					state_d = wsfe_pkg::BK_IDLE;
				end
			endcase
		end

		out_valid_d = load ? 1'b1 : (m_tready ? 1'b0 : out_valid_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wsfe_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		ent_q      <= ent_d;
		ext_q      <= ext_d;
		ext_cnt_q  <= ext_cnt_d;
		mask_q     <= mask_d;
		mcnt_q     <= mcnt_d;
		out_byte_q <= out_byte_d;
		out_last_q <= out_last_d;
	end

endmodule

// ===== hdl/websocket_masked_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// websocket_masked_frame_encoder: masked client text frame byte streamer
// Path: an accepted item passes the queue and the output register to m_tdata.
// Throughput with m_tready high: one payload item per cycle while no header
//   is in progress; a start item holds the back end for 0x81, length bytes,
//   four mask bytes and any first payload byte, sent one byte a cycle.
// Reset: arst_n clears frame state, queue and output valid asynchronously.
// ----------------------------------------------------------------------------
//
// Structure:
//   front - takes items, tracks bytes left and mask phase, masks payload
//           bytes and drops items that make no output (idle, excess bytes).
//   queue - short FIFO of classified entries; lets front keep taking items
//           while the back end is busy with a header.
//   back  - expands a start entry into 0x81, length byte, extended length,
//           four mask bytes and an optional first payload byte; passes a
//           payload entry straight to the output register.
// The output register decouples m_tready from the sequencer: a new byte is
// produced whenever the register is empty or being drained.
module websocket_masked_frame_encoder #(
	parameter int QUEUE_DEPTH = wsfe_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	// slave side: input items
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,  // [7:0] payload_byte, [70:8] frame_length,
	                               // [102:71] mask_key, [103] zero
	input  logic [1:0]   s_tuser,  // [0] has_byte, [1] frame_start
	// master side: frame bytes
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [7:0]   m_tdata,  // [7:0] out_byte
	output logic         m_tlast   // frame_end
);

	wsfe_pkg::entry_t   push_entry, head;
	wsfe_pkg::q_stat_t  q_stat;
	wsfe_pkg::bk_stat_t bk_stat;
	logic               push, pop;

	// field unpacking
	logic [wsfe_pkg::BYTE_W-1:0] payload_byte;
	logic [wsfe_pkg::LEN_W-1:0]  frame_length;
	logic [wsfe_pkg::KEY_W-1:0]  mask_key;
	logic                        has_byte, frame_start;

	assign payload_byte = s_tdata[7:0];
	assign frame_length = s_tdata[70:8];
	assign mask_key     = s_tdata[102:71];
	assign has_byte     = s_tuser[0];
	assign frame_start  = s_tuser[1];

	wsfe_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.payload_byte (payload_byte),
		.has_byte     (has_byte),
		.frame_start  (frame_start),
		.frame_length (frame_length),
		.mask_key     (mask_key),
		.q_stat       (q_stat),
		.push         (push),
		.push_entry   (push_entry)
	);

	wsfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	wsfe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.bk_stat  (bk_stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// last byte of a frame leaves only once the sequencer has finished it
	a_last_seq_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |-> bk_stat.idle)
		else $error("frame end sent while sequencer mid-frame");

	// nothing queued and nothing in progress: no byte can appear next cycle
	a_no_spurious_out: assert property (@(posedge clk) disable iff (!arst_n)
		(q_stat.empty && bk_stat.idle && !m_tvalid) |=> !m_tvalid)
		else $error("output byte without a queued entry");

	// sequencer never pops an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

endmodule
